/* rtl/fps_pkg.sv */
// Package for the prefix-sum table: field widths, opcodes and the microcode ROM.
package fps_pkg;

  localparam int OPC_W  = 2;
  localparam int IDX_W  = 11;
  localparam int SIZE_W = 11;
  localparam int AMT_W  = 32;
  localparam int SUM_W  = 48;
  // Tree walk position; one bit above IDX_W so pos + lowbit(pos) cannot overflow.
  localparam int POS_W  = IDX_W + 1;
  localparam int STEP_W = 4;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

  typedef enum logic [OPC_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_SUM   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    COND_ALWAYS     = 3'd0,
    COND_DISPATCH   = 3'd1,
    COND_SWEEP_LAST = 3'd2,
    COND_INIT       = 3'd3,
    COND_OUT_FREE   = 3'd4,
    COND_ADD_SKIP   = 3'd5,
    COND_ADD_MORE   = 3'd6,
    COND_POS_ZERO   = 3'd7
  } cond_e;

  typedef logic [STEP_W-1:0] step_t;

  // Microcode addresses
  localparam step_t S_IDLE    = 4'd0;
  localparam step_t S_CLR     = 4'd1;
  localparam step_t S_CLR_END = 4'd2;
  localparam step_t S_EMIT    = 4'd3;
  localparam step_t S_ADD_CHK = 4'd4;
  localparam step_t S_ADD_RD  = 4'd5;
  localparam step_t S_ADD_WR  = 4'd6;
  localparam step_t S_HI_RD   = 4'd7;
  localparam step_t S_HI_ACC  = 4'd8;
  localparam step_t S_LO_INIT = 4'd9;
  localparam step_t S_LO_RD   = 4'd10;
  localparam step_t S_LO_ACC  = 4'd11;
  localparam step_t S_SUM_FIN = 4'd12;

  // One control word: next = cond ? jt : jf (dispatch handled apart).
  typedef struct packed {
    cond_e cond;
    step_t jt;
    step_t jf;
    logic  latch;      // take the transaction fields
    logic  clr_wr;     // write zero at the sweep counter
    logic  init_done;  // end of the post-reset clearing pass
    logic  emit;       // load the output register
    logic  mem_rd;     // read node at pos-1
    logic  node_wr;    // write node + delta at pos-1
    logic  pos_up;     // pos += lowbit(pos)
    logic  pos_dn;     // pos -= lowbit(pos)
    logic  acc_add;    // acc += node
    logic  lo_init;    // park upper prefix, start lower chain
    logic  res_diff;   // result = upper - lower
  } uword_t;

  function automatic uword_t ucode_word(input step_t step);
    uword_t w;
    w      = '0;
    w.cond = COND_ALWAYS;
    w.jt   = S_IDLE;
    w.jf   = S_IDLE;
    case (step)
      S_IDLE: begin
        w.cond  = COND_DISPATCH;
        w.latch = 1'b1;
      end
      S_CLR: begin
        w.cond   = COND_SWEEP_LAST;
        w.jt     = S_CLR_END;
        w.jf     = S_CLR;
        w.clr_wr = 1'b1;
      end
      S_CLR_END: begin
        w.cond      = COND_INIT;
        w.jt        = S_IDLE;
        w.jf        = S_EMIT;
        w.init_done = 1'b1;
      end
      S_EMIT: begin
        w.cond = COND_OUT_FREE;
        w.jt   = S_IDLE;
        w.jf   = S_EMIT;
        w.emit = 1'b1;
      end
      S_ADD_CHK: begin
        w.cond = COND_ADD_SKIP;
        w.jt   = S_EMIT;
        w.jf   = S_ADD_RD;
      end
      S_ADD_RD: begin
        w.jt     = S_ADD_WR;
        w.mem_rd = 1'b1;
      end
      S_ADD_WR: begin
        w.cond    = COND_ADD_MORE;
        w.jt      = S_ADD_RD;
        w.jf      = S_EMIT;
        w.node_wr = 1'b1;
        w.pos_up  = 1'b1;
      end
      S_HI_RD: begin
        w.cond   = COND_POS_ZERO;
        w.jt     = S_LO_INIT;
        w.jf     = S_HI_ACC;
        w.mem_rd = 1'b1;
      end
      S_HI_ACC: begin
        w.jt      = S_HI_RD;
        w.acc_add = 1'b1;
        w.pos_dn  = 1'b1;
      end
      S_LO_INIT: begin
        w.jt      = S_LO_RD;
        w.lo_init = 1'b1;
      end
      S_LO_RD: begin
        w.cond   = COND_POS_ZERO;
        w.jt     = S_SUM_FIN;
        w.jf     = S_LO_ACC;
        w.mem_rd = 1'b1;
      end
      S_LO_ACC: begin
        w.jt      = S_LO_RD;
        w.acc_add = 1'b1;
        w.pos_dn  = 1'b1;
      end
      S_SUM_FIN: begin
        w.jt       = S_EMIT;
        w.res_diff = 1'b1;
      end
      default: begin
        w.jt = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/fps_node_ram.sv */
// Single-port node memory with registered read data.
module fps_node_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/fenwick_prefix_sum_table.sv */
// Top level of the prefix-sum table: microcoded sequencer, datapath and node memory.
//
// Binary indexed tree over positions 1..min(size register, MAX_POSITIONS), 48-bit
// wrapping two's complement nodes, one result transaction per input transaction.
// Opcode clear zeroes every node, add adds a sign-extended amount at first_index
// (ignored at position zero or above the size), range sum returns
// prefix(last) - prefix(first-1) with first zero treated as one and both ends
// clamped to the size; clear, add and opcode 3 return zero. Control is a 13-step
// microprogram in a ROM; every node access goes through one single-port memory
// with registered read data, so each node visited takes a read step and then a
// write step (add) or an accumulate step (range sum). A clear sweeps every node;
// an add checks its position and then walks up the tree; a range sum walks the
// upper chain, then the lower chain, then forms the difference. The next input
// transaction can be taken in the idle step that follows the emit step.
// After reset a clearing pass over every node runs before the first
// input transaction is taken; size writes are accepted at any time but must only
// change while the block is idle. A finished result waits in the output register
// while the next input transaction is accepted.
module fenwick_prefix_sum_table #(
  parameter int MAX_POSITIONS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fps_pkg::SIZE_W-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [fps_pkg::OPC_W-1:0]           opcode_i,
  input  logic [fps_pkg::IDX_W-1:0]           first_index_i,
  input  logic [fps_pkg::IDX_W-1:0]           last_index_i,
  input  logic signed [fps_pkg::AMT_W-1:0]    amount_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [fps_pkg::SUM_W-1:0]    range_total_o
);

  import fps_pkg::*;

  localparam int AW = $clog2(MAX_POSITIONS);

  // sequencer
  step_t  upc_q, upc_d;
  uword_t uw;
  step_t  dispatch_step;
  logic   cond_true;
  logic   init_q, init_d;
  logic [AW-1:0] clr_q, clr_d;
  logic   sweep_last;

  // config
  logic [SIZE_W-1:0] size_q;
  logic [POS_W-1:0]  eff_size;

  // datapath
  logic [POS_W-1:0] pos_q, pos_d;
  logic [IDX_W-1:0] first_q, first_d;
  logic [SUM_W-1:0] delta_q, delta_d;
  logic [SUM_W-1:0] acc_q, acc_d;
  logic [SUM_W-1:0] hi_q, hi_d;
  logic [SUM_W-1:0] res_q, res_d;
  logic [POS_W-1:0] low_bit, pos_up, pos_dn;
  logic [POS_W-1:0] hi_start, lo_start, first_m1;

  // output register
  logic [SUM_W-1:0] out_q;
  logic             out_valid_q, out_valid_d;
  logic             out_free, emit_fire;

  // node memory
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_addr;
  logic [SUM_W-1:0] ram_wdata, ram_rdata;

  logic in_accept;

  assign uw         = ucode_word(upc_q);
  assign in_stall_o = (upc_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit_fire  = uw.emit && out_free;
  assign sweep_last = (clr_q == AW'(MAX_POSITIONS - 1));

  // effective size = min(register, MAX_POSITIONS)
  always_comb begin
    if (32'(size_q) > MAX_POSITIONS) begin
      eff_size = POS_W'(MAX_POSITIONS);
    end else begin
      eff_size = POS_W'(size_q);
    end
  end

  // tree index arithmetic
  assign low_bit  = pos_q & (~pos_q + POS_W'(1));
  assign pos_up   = pos_q + low_bit;
  assign pos_dn   = pos_q & (pos_q - POS_W'(1));
  assign hi_start = (POS_W'(last_index_i) > eff_size) ? eff_size : POS_W'(last_index_i);
  assign first_m1 = (first_q == '0) ? '0 : POS_W'(first_q) - POS_W'(1);
  assign lo_start = (first_m1 > eff_size) ? eff_size : first_m1;

  always_comb begin
    case (opcode_i)
      OP_CLEAR: dispatch_step = S_CLR;
      OP_ADD:   dispatch_step = S_ADD_CHK;
      OP_SUM:   dispatch_step = S_HI_RD;
      default:  dispatch_step = S_EMIT;
    endcase
  end

  always_comb begin
    case (uw.cond)
      COND_ALWAYS:     cond_true = 1'b1;
      COND_SWEEP_LAST: cond_true = sweep_last;
      COND_INIT:       cond_true = init_q;
      COND_OUT_FREE:   cond_true = out_free;
      COND_ADD_SKIP:   cond_true = (pos_q == '0) || (pos_q > eff_size);
      COND_ADD_MORE:   cond_true = (pos_up <= eff_size);
      COND_POS_ZERO:   cond_true = (pos_q == '0);
      default:         cond_true = 1'b0;
    endcase
  end

  always_comb begin
    if (uw.cond == COND_DISPATCH) begin
      upc_d = in_accept ? dispatch_step : S_IDLE;
    end else begin
      upc_d = cond_true ? uw.jt : uw.jf;
    end
  end

  always_comb begin
    init_d = uw.init_done ? 1'b0 : init_q;
    clr_d  = clr_q;
    if (uw.clr_wr) begin
      clr_d = sweep_last ? '0 : clr_q + AW'(1);
    end
  end

  always_comb begin
    pos_d   = pos_q;
    first_d = first_q;
    delta_d = delta_q;
    acc_d   = acc_q;
    hi_d    = hi_q;
    res_d   = res_q;
    if (uw.latch && in_accept) begin
      first_d = first_index_i;
      delta_d = {{(SUM_W - AMT_W){amount_i[AMT_W-1]}}, amount_i};
      pos_d   = (opcode_i == OP_SUM) ? hi_start : POS_W'(first_index_i);
      acc_d   = '0;
      res_d   = '0;
    end
    if (uw.pos_up) begin
      pos_d = pos_up;
    end
    if (uw.pos_dn) begin
      pos_d = pos_dn;
    end
    if (uw.acc_add) begin
      acc_d = acc_q + ram_rdata;
    end
    if (uw.lo_init) begin
      hi_d  = acc_q;
      acc_d = '0;
      pos_d = lo_start;
    end
    if (uw.res_diff) begin
      res_d = hi_q - acc_q;
    end
  end

  // node memory port: sweep counter during clears, pos-1 otherwise
  assign ram_we    = uw.clr_wr || uw.node_wr;
  assign ram_re    = uw.mem_rd && (pos_q != '0);
  assign ram_addr  = uw.clr_wr ? clr_q : AW'(pos_q - POS_W'(1));
  assign ram_wdata = uw.clr_wr ? '0 : ram_rdata + delta_q;

  fps_node_ram #(
    .DEPTH (MAX_POSITIONS),
    .WIDTH (SUM_W)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign out_valid_d = emit_fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= S_CLR;
      init_q      <= 1'b1;
      clr_q       <= '0;
      size_q      <= SIZE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      init_q      <= init_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    first_q <= first_d;
    delta_q <= delta_d;
    acc_q   <= acc_d;
    hi_q    <= hi_d;
    res_q   <= res_d;
    if (emit_fire) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign range_total_o = out_q;

  // a new result only comes from the emit step
  a_rise_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(upc_q) == S_EMIT)
    else $error("result appeared outside the emit step");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |-> !(out_valid_q && out_stall_i))
    else $error("output register overwritten while stalled");

  // no input transaction during the post-reset clearing pass
  a_no_accept_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> !init_q)
    else $error("input accepted before the clearing pass finished");

  // update walk stays inside the table
  a_add_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == S_ADD_RD || upc_q == S_ADD_WR) |-> (pos_q != '0) && (pos_q <= eff_size))
    else $error("update walk left the table");

endmodule
